// ----- hdl/usvt_pkg.sv -----
// ----------------------------------------------------------------------------
// usvt_pkg: shared types and codes for the unique value set table
// Request and result item layouts, request kinds and status codes.
// ----------------------------------------------------------------------------
package usvt_pkg;

	localparam int ValueW = 32;
	localparam int CountOutW = 7;

	// request kinds; the spare code is served as a lookup
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_LOOKUP = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_DUP    = 2'd1;
	localparam logic [1:0] ST_ABSENT = 2'd2;
	localparam logic [1:0] ST_FULL   = 2'd3;

	typedef struct packed {
		logic [1:0]               req_type;
		logic signed [ValueW-1:0] value;
	} req_t;

	typedef struct packed {
		logic                 success;
		logic [1:0]           status;
		logic [CountOutW-1:0] entry_count;
		logic                 is_empty;
	} res_t;

endpackage

// ----- hdl/unique_value_set_table.sv -----
// ----------------------------------------------------------------------------
// unique_value_set_table: set of distinct 32-bit values in insertion order
// Insert (rejecting duplicates), remove (closing the gap) and lookup over a
// single-port table, walked one entry at a time by a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel  | ports                  | handshake
//  ---------+------------------------+------------------------------------------
//  request  | start, busy, req       | item taken on a clock edge with start & !busy
//  result   | done, res              | one-cycle strobe, receiver cannot stall
//
//  Sequence: the scan reads each entry through the single table port, then
//  compares it against the registered read data; a remove then moves each
//  later entry down with one read and one write, starting where the scan
//  left off.
//  Reset: count and sequencer clear at once; table contents are not cleared,
//  only data read from positions below the count is ever used.
//  The result is shown for one cycle as busy falls; a new item may be taken
//  in that same cycle.
//
module unique_value_set_table #(
	parameter int CAPACITY = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  usvt_pkg::req_t  req,
	output logic            done,
	output usvt_pkg::res_t  res
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,    // read entry idx, or conclude at the end of the set that the value is not held
		S_CMP,   // compare registered entry with the request value
		S_SHRD,  // read the entry above the gap
		S_SHWR,  // move it down into the gap
		S_INS    // append the new value
	} state_t;

	state_t               state_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        idx_q;
	logic [1:0]           kind_q;
	logic [31:0]          val_q;
	logic                 done_q;
	usvt_pkg::res_t       res_q;

	// table, one port, registered read data
	logic [31:0]          mem [CAPACITY];
	logic [31:0]          rdata_q;
	logic [AW-1:0]        addr;
	logic                 we;
	logic [31:0]          wdata;

	logic [CW-1:0]        idx_nx;
	logic [CW-1:0]        count_dec;
	logic [CW-1:0]        count_inc;
	logic                 hit;

	assign idx_nx    = idx_q + CW'(1);
	assign count_dec = count_q - CW'(1);
	assign count_inc = count_q + CW'(1);
	assign hit       = (rdata_q == val_q);

	// table port steering
	always_comb begin
		addr  = idx_q[AW-1:0];
		we    = 1'b0;
		wdata = rdata_q;
		case (state_q)
			S_SHRD: addr = idx_nx[AW-1:0];
			S_SHWR: we = 1'b1;
			S_INS: begin
				addr  = count_q[AW-1:0];
				we    = 1'b1;
				wdata = val_q;
			end
			default: addr = idx_q[AW-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	// sequencer, count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			kind_q  <= usvt_pkg::REQ_LOOKUP;
			val_q   <= '0;
			done_q  <= 1'b0;
			res_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						kind_q  <= req.req_type;
						val_q   <= $unsigned(req.value);
						idx_q   <= '0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					if (idx_q == count_q) begin
						// value not held
						if (kind_q == usvt_pkg::REQ_INSERT && count_q < CapCount) begin
							state_q <= S_INS;
						end else begin
							done_q            <= 1'b1;
							res_q.success     <= 1'b0;
							res_q.status      <= (kind_q == usvt_pkg::REQ_INSERT) ?
								usvt_pkg::ST_FULL : usvt_pkg::ST_ABSENT;
							res_q.entry_count <= usvt_pkg::CountOutW'(count_q);
							res_q.is_empty    <= (count_q == '0);
							state_q           <= S_IDLE;
						end
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (hit) begin
						if (kind_q == usvt_pkg::REQ_REMOVE) begin
							state_q <= S_SHRD;
						end else begin
							done_q            <= 1'b1;
							res_q.success     <= (kind_q != usvt_pkg::REQ_INSERT);
							res_q.status      <= (kind_q == usvt_pkg::REQ_INSERT) ?
								usvt_pkg::ST_DUP : usvt_pkg::ST_OK;
							res_q.entry_count <= usvt_pkg::CountOutW'(count_q);
							res_q.is_empty    <= (count_q == '0);
							state_q           <= S_IDLE;
						end
					end else begin
						idx_q   <= idx_nx;
						state_q <= S_RD;
					end
				end
				S_SHRD: begin
					if (idx_nx < count_q) begin
						state_q <= S_SHWR;
					end else begin
						count_q           <= count_dec;
						done_q            <= 1'b1;
						res_q.success     <= 1'b1;
						res_q.status      <= usvt_pkg::ST_OK;
						res_q.entry_count <= usvt_pkg::CountOutW'(count_dec);
						res_q.is_empty    <= (count_dec == '0);
						state_q           <= S_IDLE;
					end
				end
				S_SHWR: begin
					idx_q   <= idx_nx;
					state_q <= S_SHRD;
				end
				S_INS: begin
					count_q           <= count_inc;
					done_q            <= 1'b1;
					res_q.success     <= 1'b1;
					res_q.status      <= usvt_pkg::ST_OK;
					res_q.entry_count <= usvt_pkg::CountOutW'(count_inc);
					res_q.is_empty    <= 1'b0;
					state_q           <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign res  = res_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CapCount)
		else $error("entry count beyond capacity");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while sequencer active");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted item did not start the sequencer");

	a_ok_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.success) |-> (res.status == usvt_pkg::ST_OK))
		else $error("success with non-ok status");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> done)
		else $error("count changed without a result");

endmodule
